>>> hdl/mov_enc_pkg.sv
// shared types and constants for the mov encoder
package mov_enc_pkg;

  localparam int MAX_WORDS = 10;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_COUNT    = 3'd1,
    ERR_REG      = 3'd2,
    ERR_SIZE     = 3'd3,
    ERR_IMM      = 3'd4,
    ERR_ADDR     = 3'd5,
    ERR_OPERANDS = 3'd6
  } err_t;

  typedef enum logic [1:0] {
    KIND_REG   = 2'd0,
    KIND_IMM   = 2'd1,
    KIND_LABEL = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    SIZE_B = 2'd0,
    SIZE_W = 2'd1,
    SIZE_D = 2'd2,
    SIZE_Q = 2'd3
  } size_t;

  localparam logic [7:0] OP_MOV_RM8   = 8'h88;
  localparam logic [7:0] OP_MOV_RM    = 8'h89;
  localparam logic [7:0] OP_MOV_R8    = 8'h8A;
  localparam logic [7:0] OP_MOV_R     = 8'h8B;
  localparam logic [7:0] OP_MOV_IMM8  = 8'hB0;
  localparam logic [7:0] OP_MOV_IMM   = 8'hB8;
  localparam logic [7:0] OP_MOV_MI8   = 8'hC6;
  localparam logic [7:0] OP_MOV_MI    = 8'hC7;
  localparam logic [7:0] PFX_OPSIZE   = 8'h66;
  localparam logic [7:0] PFX_ADDRSIZE = 8'h67;
  localparam logic [7:0] PFX_REX_W    = 8'h48;
  localparam logic [7:0] MODRM_REG    = 8'hC0;
  localparam logic [2:0] RM_RIP       = 3'd5;

  typedef struct packed {
    logic [MAX_WORDS-1:0][7:0] bytes;
    logic [3:0]                count;
    logic                      mark;
    logic [11:0]               label;
    err_t                      err;
  } desc_t;

endpackage

>>> hdl/x86_mov_instruction_encoder.sv
// top level of the mov instruction encoder
// a taken request is written into the queue, then loaded into the back end's word register once that is free
// throughput: one word per cycle while requests are pending; a request gives 1 to 10 words
// (its word count), so the back end's single output word per cycle sets the rate
// a queue of QUEUE_DEPTH requests lets the front keep accepting while words go out
// reset clears the queue and the emitter; no words are pending after reset
module x86_mov_instruction_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operand_count,
  input  logic [1:0]  dest_kind,
  input  logic        dest_indirect,
  input  logic [3:0]  dest_code,
  input  logic [1:0]  dest_size_log2,
  input  logic [1:0]  src_kind,
  input  logic        src_indirect,
  input  logic [3:0]  src_code,
  input  logic [1:0]  src_size_log2,
  input  logic [63:0] immediate,
  input  logic [11:0] label_id,
  output logic        valid,
  output logic [7:0]  out_byte,
  output logic        is_label_ref,
  output logic [11:0] ref_label,
  output logic [2:0]  error_code,
  output logic        last
);

  mov_enc_pkg::desc_t wdesc, head;
  logic push, pop, empty, full;

  assign busy = full;

  mov_enc_front u_front (
    .start          (start),
    .full           (full),
    .operand_count  (operand_count),
    .dest_kind      (dest_kind),
    .dest_indirect  (dest_indirect),
    .dest_code      (dest_code),
    .dest_size_log2 (dest_size_log2),
    .src_kind       (src_kind),
    .src_indirect   (src_indirect),
    .src_code       (src_code),
    .src_size_log2  (src_size_log2),
    .immediate      (immediate),
    .label_id       (label_id),
    .push           (push),
    .desc           (wdesc)
  );

  mov_enc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wdesc),
    .pop   (pop),
    .rdata (head),
    .empty (empty),
    .full  (full)
  );

  mov_enc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .valid        (valid),
    .out_byte     (out_byte),
    .is_label_ref (is_label_ref),
    .ref_label    (ref_label),
    .error_code   (error_code),
    .last         (last)
  );

endmodule

>>> hdl/mov_enc_front.sv
// front end: accepts a request and classifies it into a word list
module mov_enc_front (
  input  logic                 start,
  input  logic                 full,
  input  logic [1:0]           operand_count,
  input  logic [1:0]           dest_kind,
  input  logic                 dest_indirect,
  input  logic [3:0]           dest_code,
  input  logic [1:0]           dest_size_log2,
  input  logic [1:0]           src_kind,
  input  logic                 src_indirect,
  input  logic [3:0]           src_code,
  input  logic [1:0]           src_size_log2,
  input  logic [63:0]          immediate,
  input  logic [11:0]          label_id,
  output logic                 push,
  output mov_enc_pkg::desc_t   desc
);

  logic fits8, fits16, fits32;
  logic dreg, sreg, simm, slbl;

  assign push   = start && !full;
  assign fits8  = (immediate[63:8] == '0);
  assign fits16 = (immediate[63:16] == '0);
  assign fits32 = (immediate[63:32] == '0);
  assign dreg   = (dest_kind == mov_enc_pkg::KIND_REG);
  assign sreg   = (src_kind == mov_enc_pkg::KIND_REG);
  assign simm   = (src_kind == mov_enc_pkg::KIND_IMM);
  assign slbl   = (src_kind == mov_enc_pkg::KIND_LABEL);

  always_comb begin
    mov_enc_pkg::desc_t d;
    mov_enc_pkg::err_t  e;
    logic [3:0]         n;
    logic [2:0]         dc, sc;
    d  = '0;
    e  = mov_enc_pkg::ERR_NONE;
    n  = '0;
    dc = dest_code[2:0];
    sc = src_code[2:0];
    if (operand_count != 2'd2) begin
      e = mov_enc_pkg::ERR_COUNT;
    end else if ((dreg && dest_code[3]) || (sreg && src_code[3])) begin
      e = mov_enc_pkg::ERR_REG;
    end else if (!dreg) begin
      e = mov_enc_pkg::ERR_OPERANDS;
    end else if (!dest_indirect && sreg && !src_indirect) begin
      // reg to reg
      if (dest_size_log2 != src_size_log2) begin
        e = mov_enc_pkg::ERR_SIZE;
      end else begin
        unique case (mov_enc_pkg::size_t'(dest_size_log2))
          mov_enc_pkg::SIZE_B: begin
            d.bytes[n] = mov_enc_pkg::OP_MOV_RM8; n = n + 4'd1;
          end
          mov_enc_pkg::SIZE_W: begin
            d.bytes[n] = mov_enc_pkg::PFX_OPSIZE; n = n + 4'd1;
            d.bytes[n] = mov_enc_pkg::OP_MOV_RM;  n = n + 4'd1;
          end
          mov_enc_pkg::SIZE_D: begin
            d.bytes[n] = mov_enc_pkg::OP_MOV_RM;  n = n + 4'd1;
          end
          mov_enc_pkg::SIZE_Q: begin
            d.bytes[n] = mov_enc_pkg::PFX_REX_W;  n = n + 4'd1;
            d.bytes[n] = mov_enc_pkg::OP_MOV_RM;  n = n + 4'd1;
          end
        endcase
        d.bytes[n] = mov_enc_pkg::MODRM_REG | {2'b00, sc, dc}; n = n + 4'd1;
      end
    end else if (!dest_indirect && simm) begin
      // immediate to reg
      if (dest_size_log2 == mov_enc_pkg::SIZE_B) begin
        if (!fits8) begin
          e = mov_enc_pkg::ERR_IMM;
        end else begin
          d.bytes[n] = mov_enc_pkg::OP_MOV_IMM8 | {5'b0, dc}; n = n + 4'd1;
          d.bytes[n] = immediate[7:0]; n = n + 4'd1;
        end
      end else if (dest_size_log2 == mov_enc_pkg::SIZE_W) begin
        if (!fits16) begin
          e = mov_enc_pkg::ERR_IMM;
        end else begin
          d.bytes[n] = mov_enc_pkg::PFX_OPSIZE; n = n + 4'd1;
          d.bytes[n] = mov_enc_pkg::OP_MOV_IMM | {5'b0, dc}; n = n + 4'd1;
          d.bytes[n] = immediate[7:0];  n = n + 4'd1;
          d.bytes[n] = immediate[15:8]; n = n + 4'd1;
        end
      end else if (!fits32) begin
        if (dest_size_log2 != mov_enc_pkg::SIZE_Q) begin
          e = mov_enc_pkg::ERR_IMM;
        end else begin
          d.bytes[n] = mov_enc_pkg::PFX_REX_W; n = n + 4'd1;
          d.bytes[n] = mov_enc_pkg::OP_MOV_IMM | {5'b0, dc}; n = n + 4'd1;
          for (int i = 0; i < 8; i++) begin
            d.bytes[n] = immediate[8*i +: 8]; n = n + 4'd1;
          end
        end
      end else begin
        d.bytes[n] = mov_enc_pkg::OP_MOV_IMM | {5'b0, dc}; n = n + 4'd1;
        for (int i = 0; i < 4; i++) begin
          d.bytes[n] = immediate[8*i +: 8]; n = n + 4'd1;
        end
      end
    end else if (dest_indirect && simm) begin
      // immediate to [reg]
      if (!fits32) begin
        e = mov_enc_pkg::ERR_IMM;
      end else if (dest_size_log2 == mov_enc_pkg::SIZE_B ||
                   dest_size_log2 == mov_enc_pkg::SIZE_W) begin
        e = mov_enc_pkg::ERR_ADDR;
      end else if (fits8) begin
        if (dest_size_log2 == mov_enc_pkg::SIZE_D) begin
          d.bytes[n] = mov_enc_pkg::PFX_ADDRSIZE; n = n + 4'd1;
        end
        d.bytes[n] = mov_enc_pkg::OP_MOV_MI8; n = n + 4'd1;
        d.bytes[n] = {5'b0, dc};              n = n + 4'd1;
        d.bytes[n] = immediate[7:0];          n = n + 4'd1;
      end else if (fits16) begin
        d.bytes[n] = mov_enc_pkg::PFX_OPSIZE; n = n + 4'd1;
        if (dest_size_log2 == mov_enc_pkg::SIZE_D) begin
          d.bytes[n] = mov_enc_pkg::PFX_ADDRSIZE; n = n + 4'd1;
        end
        d.bytes[n] = mov_enc_pkg::OP_MOV_MI; n = n + 4'd1;
        d.bytes[n] = {5'b0, dc};             n = n + 4'd1;
        d.bytes[n] = immediate[7:0];         n = n + 4'd1;
        d.bytes[n] = immediate[15:8];        n = n + 4'd1;
      end else begin
        if (dest_size_log2 == mov_enc_pkg::SIZE_D) begin
          d.bytes[n] = mov_enc_pkg::PFX_ADDRSIZE; n = n + 4'd1;
        end
        d.bytes[n] = mov_enc_pkg::OP_MOV_MI; n = n + 4'd1;
        d.bytes[n] = {5'b0, dc};             n = n + 4'd1;
        for (int i = 0; i < 4; i++) begin
          d.bytes[n] = immediate[8*i +: 8]; n = n + 4'd1;
        end
      end
    end else if (dest_indirect && sreg && !src_indirect) begin
      // reg to [reg]
      if (dest_size_log2 == mov_enc_pkg::SIZE_B ||
          dest_size_log2 == mov_enc_pkg::SIZE_W) begin
        e = mov_enc_pkg::ERR_ADDR;
      end else begin
        if (src_size_log2 == mov_enc_pkg::SIZE_W) begin
          d.bytes[n] = mov_enc_pkg::PFX_OPSIZE; n = n + 4'd1;
        end
        if (dest_size_log2 == mov_enc_pkg::SIZE_D) begin
          d.bytes[n] = mov_enc_pkg::PFX_ADDRSIZE; n = n + 4'd1;
        end
        if (src_size_log2 == mov_enc_pkg::SIZE_Q) begin
          d.bytes[n] = mov_enc_pkg::PFX_REX_W; n = n + 4'd1;
        end
        d.bytes[n] = (src_size_log2 == mov_enc_pkg::SIZE_B) ?
                     mov_enc_pkg::OP_MOV_RM8 : mov_enc_pkg::OP_MOV_RM;
        n = n + 4'd1;
        d.bytes[n] = {2'b00, sc, dc}; n = n + 4'd1;
      end
    end else if (!dest_indirect && sreg && src_indirect) begin
      // [reg] to reg
      if (src_size_log2 == mov_enc_pkg::SIZE_B ||
          src_size_log2 == mov_enc_pkg::SIZE_W) begin
        e = mov_enc_pkg::ERR_ADDR;
      end else begin
        if (dest_size_log2 == mov_enc_pkg::SIZE_W) begin
          d.bytes[n] = mov_enc_pkg::PFX_OPSIZE; n = n + 4'd1;
        end
        if (src_size_log2 == mov_enc_pkg::SIZE_D) begin
          d.bytes[n] = mov_enc_pkg::PFX_ADDRSIZE; n = n + 4'd1;
        end
        if (dest_size_log2 == mov_enc_pkg::SIZE_Q) begin
          d.bytes[n] = mov_enc_pkg::PFX_REX_W; n = n + 4'd1;
        end
        d.bytes[n] = (dest_size_log2 == mov_enc_pkg::SIZE_B) ?
                     mov_enc_pkg::OP_MOV_R8 : mov_enc_pkg::OP_MOV_R;
        n = n + 4'd1;
        d.bytes[n] = {2'b00, dc, sc}; n = n + 4'd1;
      end
    end else if (!dest_indirect && slbl) begin
      // rip-relative label load, closed by a marker word
      if (dest_size_log2 == mov_enc_pkg::SIZE_Q) begin
        d.bytes[n] = mov_enc_pkg::PFX_REX_W; n = n + 4'd1;
      end else if (dest_size_log2 == mov_enc_pkg::SIZE_W) begin
        d.bytes[n] = mov_enc_pkg::PFX_OPSIZE; n = n + 4'd1;
      end
      d.bytes[n] = (dest_size_log2 == mov_enc_pkg::SIZE_B) ?
                   mov_enc_pkg::OP_MOV_R8 : mov_enc_pkg::OP_MOV_R;
      n = n + 4'd1;
      d.bytes[n] = {2'b00, dc, mov_enc_pkg::RM_RIP}; n = n + 4'd1;
      n       = n + 4'd1;
      d.mark  = 1'b1;
      d.label = label_id;
    end else begin
      e = mov_enc_pkg::ERR_OPERANDS;
    end
    if (e != mov_enc_pkg::ERR_NONE) begin
      d       = '0;
      d.err   = e;
      d.count = 4'd1;
    end else begin
      d.count = n;
    end
    desc = d;
  end

endmodule

>>> hdl/mov_enc_queue.sv
// short queue of classified requests between front and back
module mov_enc_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mov_enc_pkg::desc_t wdata,
  input  logic               pop,
  output mov_enc_pkg::desc_t rdata,
  output logic               empty,
  output logic               full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mov_enc_pkg::desc_t entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && !pop |=> count == CW'(DEPTH) && $stable(wr_ptr))
    else $error("queue pointer moved while full");

endmodule

>>> hdl/mov_enc_back.sv
// back end: emits one word per cycle from the head request
module mov_enc_back (
  input  logic               clk,
  input  logic               rst,
  input  mov_enc_pkg::desc_t head,
  input  logic               empty,
  output logic               pop,
  output logic               valid,
  output logic [7:0]         out_byte,
  output logic               is_label_ref,
  output logic [11:0]        ref_label,
  output logic [2:0]         error_code,
  output logic               last
);

  mov_enc_pkg::desc_t cur;
  logic [3:0]         rem;

  assign valid        = (rem != '0);
  assign last         = (rem == 4'd1);
  assign pop          = (rem <= 4'd1) && !empty;
  assign out_byte     = cur.bytes[0];
  assign is_label_ref = valid && last && cur.mark;
  assign ref_label    = is_label_ref ? cur.label : '0;
  assign error_code   = cur.err;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end else if (valid) begin
      cur.bytes <= cur.bytes >> 8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (pop) begin
      rem <= head.count;
    end else if (valid) begin
      rem <= rem - 4'd1;
    end
  end

  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    is_label_ref |-> last && out_byte == 8'h00)
    else $error("label marker not on final word");

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    valid && error_code != mov_enc_pkg::ERR_NONE |-> last && out_byte == 8'h00)
    else $error("error word not alone");

  a_words_contiguous: assert property (@(posedge clk) disable iff (rst)
    valid && !last |=> valid)
    else $error("gap inside an instruction");

endmodule

>>> verif/mov_enc_checker.sv
// checker for the mov encoder: predicts the code words of each request and compares them
`timescale 1ns / 100ps

module mov_enc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  operand_count,
  input  logic [1:0]  dest_kind,
  input  logic        dest_indirect,
  input  logic [3:0]  dest_code,
  input  logic [1:0]  dest_size_log2,
  input  logic [1:0]  src_kind,
  input  logic        src_indirect,
  input  logic [3:0]  src_code,
  input  logic [1:0]  src_size_log2,
  input  logic [63:0] immediate,
  input  logic [11:0] label_id,
  input  logic        valid,
  input  logic [7:0]  out_byte,
  input  logic        is_label_ref,
  input  logic [11:0] ref_label,
  input  logic [2:0]  error_code,
  input  logic        last,
  output int          mismatches,
  output int          pending,
  output int          requests,
  output int          words,
  output int          error_words,
  output int          label_marks
);

  typedef struct packed {
    logic [7:0]        data;
    logic              mark;
    logic [11:0]       lbl;
    mov_enc_pkg::err_t err;
    logic              fin;
  } mov_word_t;

  mov_word_t expected_words[$];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("%0t checker: %s got %0h expected %0h", $time, what, got, want);
  endtask

  function automatic void encode_mov();
    logic [7:0]        code[$];
    logic [1:0]        dk, sk, ds, ss;
    logic [3:0]        dc, sc;
    logic              di, si, marker;
    logic [63:0]       imm;
    mov_enc_pkg::err_t fault;
    int                nbytes, i;
    mov_word_t         w;
    dk = dest_kind;
    di = dest_indirect;
    dc = dest_code;
    ds = dest_size_log2;
    sk = src_kind;
    si = src_indirect;
    sc = src_code;
    ss = src_size_log2;
    imm = immediate;
    fault = mov_enc_pkg::ERR_NONE;
    marker = 1'b0;
    nbytes = 4;
    if (operand_count != 2'd2) fault = mov_enc_pkg::ERR_COUNT;
    else if ((dk == mov_enc_pkg::KIND_REG && dc >= 4'd8) ||
             (sk == mov_enc_pkg::KIND_REG && sc >= 4'd8)) fault = mov_enc_pkg::ERR_REG;
    else if (dk != mov_enc_pkg::KIND_REG) fault = mov_enc_pkg::ERR_OPERANDS;
    else if (!di && sk == mov_enc_pkg::KIND_REG && !si) begin
      if (ds != ss) fault = mov_enc_pkg::ERR_SIZE;
      else begin
        case (ds)
          mov_enc_pkg::SIZE_B: code.push_back(mov_enc_pkg::OP_MOV_RM8);
          mov_enc_pkg::SIZE_W: begin
            code.push_back(mov_enc_pkg::PFX_OPSIZE);
            code.push_back(mov_enc_pkg::OP_MOV_RM);
          end
          mov_enc_pkg::SIZE_D: code.push_back(mov_enc_pkg::OP_MOV_RM);
          default: begin
            code.push_back(mov_enc_pkg::PFX_REX_W);
            code.push_back(mov_enc_pkg::OP_MOV_RM);
          end
        endcase
        code.push_back(8'(mov_enc_pkg::MODRM_REG + dc + 8 * sc));
      end
    end else if (!di && sk == mov_enc_pkg::KIND_IMM) begin
      if (ds == mov_enc_pkg::SIZE_B) begin
        if (imm > 64'hFF) fault = mov_enc_pkg::ERR_IMM;
        else begin
          code.push_back(8'(mov_enc_pkg::OP_MOV_IMM8 + dc));
          code.push_back(imm[7:0]);
        end
      end else if (ds == mov_enc_pkg::SIZE_W) begin
        if (imm > 64'hFFFF) fault = mov_enc_pkg::ERR_IMM;
        else begin
          code.push_back(mov_enc_pkg::PFX_OPSIZE);
          code.push_back(8'(mov_enc_pkg::OP_MOV_IMM + dc));
          code.push_back(imm[7:0]);
          code.push_back(imm[15:8]);
        end
      end else begin
        if (imm > 64'hFFFF_FFFF) begin
          if (ds != mov_enc_pkg::SIZE_Q) fault = mov_enc_pkg::ERR_IMM;
          nbytes = 8;
          code.push_back(mov_enc_pkg::PFX_REX_W);
        end
        if (fault == mov_enc_pkg::ERR_NONE) begin
          code.push_back(8'(mov_enc_pkg::OP_MOV_IMM + dc));
          for (i = 0; i < nbytes; i++) code.push_back(imm[8*i +: 8]);
        end
      end
    end else if (di && sk == mov_enc_pkg::KIND_IMM) begin
      if (imm > 64'hFFFF_FFFF) fault = mov_enc_pkg::ERR_IMM;
      else if (ds == mov_enc_pkg::SIZE_B || ds == mov_enc_pkg::SIZE_W)
        fault = mov_enc_pkg::ERR_ADDR;
      else begin
        if (imm <= 64'hFF) nbytes = 1;
        else if (imm <= 64'hFFFF) begin
          nbytes = 2;
          code.push_back(mov_enc_pkg::PFX_OPSIZE);
        end
        if (ds == mov_enc_pkg::SIZE_D) code.push_back(mov_enc_pkg::PFX_ADDRSIZE);
        code.push_back(nbytes == 1 ? mov_enc_pkg::OP_MOV_MI8 : mov_enc_pkg::OP_MOV_MI);
        code.push_back({4'd0, dc});
        for (i = 0; i < nbytes; i++) code.push_back(imm[8*i +: 8]);
      end
    end else if (di && sk == mov_enc_pkg::KIND_REG && !si) begin
      if (ds == mov_enc_pkg::SIZE_B || ds == mov_enc_pkg::SIZE_W)
        fault = mov_enc_pkg::ERR_ADDR;
      else begin
        if (ss == mov_enc_pkg::SIZE_W) code.push_back(mov_enc_pkg::PFX_OPSIZE);
        if (ds == mov_enc_pkg::SIZE_D) code.push_back(mov_enc_pkg::PFX_ADDRSIZE);
        if (ss == mov_enc_pkg::SIZE_Q) code.push_back(mov_enc_pkg::PFX_REX_W);
        code.push_back(ss == mov_enc_pkg::SIZE_B ? mov_enc_pkg::OP_MOV_RM8
                                                 : mov_enc_pkg::OP_MOV_RM);
        code.push_back(8'(dc + 8 * sc));
      end
    end else if (!di && sk == mov_enc_pkg::KIND_REG && si) begin
      if (ss == mov_enc_pkg::SIZE_B || ss == mov_enc_pkg::SIZE_W)
        fault = mov_enc_pkg::ERR_ADDR;
      else begin
        if (ds == mov_enc_pkg::SIZE_W) code.push_back(mov_enc_pkg::PFX_OPSIZE);
        if (ss == mov_enc_pkg::SIZE_D) code.push_back(mov_enc_pkg::PFX_ADDRSIZE);
        if (ds == mov_enc_pkg::SIZE_Q) code.push_back(mov_enc_pkg::PFX_REX_W);
        code.push_back(ds == mov_enc_pkg::SIZE_B ? mov_enc_pkg::OP_MOV_R8
                                                 : mov_enc_pkg::OP_MOV_R);
        code.push_back(8'(sc + 8 * dc));
      end
    end else if (!di && sk == mov_enc_pkg::KIND_LABEL) begin
      if (ds == mov_enc_pkg::SIZE_Q) code.push_back(mov_enc_pkg::PFX_REX_W);
      else if (ds == mov_enc_pkg::SIZE_W) code.push_back(mov_enc_pkg::PFX_OPSIZE);
      code.push_back(ds == mov_enc_pkg::SIZE_B ? mov_enc_pkg::OP_MOV_R8
                                               : mov_enc_pkg::OP_MOV_R);
      code.push_back({1'b0, dc, mov_enc_pkg::RM_RIP});
      marker = 1'b1;
    end else fault = mov_enc_pkg::ERR_OPERANDS;

    if (fault != mov_enc_pkg::ERR_NONE) begin
      w.data = 8'h00;
      w.mark = 1'b0;
      w.lbl = 12'h000;
      w.err = fault;
      w.fin = 1'b1;
      expected_words.push_back(w);
    end else begin
      for (i = 0; i < code.size(); i++) begin
        w.data = code[i];
        w.mark = 1'b0;
        w.lbl = 12'h000;
        w.err = mov_enc_pkg::ERR_NONE;
        w.fin = (i == code.size() - 1) && !marker;
        expected_words.push_back(w);
      end
      if (marker) begin
        w.data = 8'h00;
        w.mark = 1'b1;
        w.lbl = label_id;
        w.err = mov_enc_pkg::ERR_NONE;
        w.fin = 1'b1;
        expected_words.push_back(w);
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    mov_word_t w;
    if (rst) expected_words.delete();
    else begin
      if (valid) begin
        words++;
        if (error_code != mov_enc_pkg::ERR_NONE) error_words++;
        if (is_label_ref) label_marks++;
        if (expected_words.size() == 0) begin
          report_mismatch("word with nothing expected, byte", out_byte, 64'd0);
        end else begin
          w = expected_words.pop_front();
          if (out_byte !== w.data) report_mismatch("out_byte", out_byte, w.data);
          if (is_label_ref !== w.mark) report_mismatch("is_label_ref", is_label_ref, w.mark);
          if (ref_label !== w.lbl) report_mismatch("ref_label", ref_label, w.lbl);
          if (error_code !== w.err) report_mismatch("error_code", error_code, w.err);
          if (last !== w.fin) report_mismatch("last", last, w.fin);
        end
      end
      if (start && !busy) begin
        requests++;
        encode_mov();
      end
    end
    pending = expected_words.size();
  end

endmodule

>>> verif/tb.sv
// testbench top for the mov encoder: request stimulus, watchdog and verdict
`timescale 1ns / 100ps

module tb;

  localparam int RANDOM_REQS = 300;
  localparam int CALM_TAIL   = 60;
  localparam int STALL_LIMIT = 1000;

  typedef struct packed {
    logic [1:0]  cnt;
    logic [1:0]  dk;
    logic        di;
    logic [3:0]  dc;
    logic [1:0]  ds;
    logic [1:0]  sk;
    logic        si;
    logic [3:0]  sc;
    logic [1:0]  ss;
    logic [63:0] imm;
    logic [11:0] lbl;
  } mov_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  operand_count = 2'd0;
  logic [1:0]  dest_kind = 2'd0;
  logic        dest_indirect = 1'b0;
  logic [3:0]  dest_code = 4'd0;
  logic [1:0]  dest_size_log2 = 2'd0;
  logic [1:0]  src_kind = 2'd0;
  logic        src_indirect = 1'b0;
  logic [3:0]  src_code = 4'd0;
  logic [1:0]  src_size_log2 = 2'd0;
  logic [63:0] immediate = 64'd0;
  logic [11:0] label_id = 12'd0;
  logic        busy;
  logic        valid;
  logic [7:0]  out_byte;
  logic        is_label_ref;
  logic [11:0] ref_label;
  logic [2:0]  error_code;
  logic        last;
  int          mismatches, pending, requests, words, error_words, label_marks;

  always #5 clk = ~clk;

  x86_mov_instruction_encoder u_dut (.*);

  mov_enc_checker u_checker (.*);

  function automatic mov_req_t mk(input logic [1:0] cnt, input logic [1:0] dk, input logic di,
                                  input logic [3:0] dc, input logic [1:0] ds,
                                  input logic [1:0] sk, input logic si, input logic [3:0] sc,
                                  input logic [1:0] ss, input logic [63:0] imm,
                                  input logic [11:0] lbl);
    return '{cnt, dk, di, dc, ds, sk, si, sc, ss, imm, lbl};
  endfunction

  function automatic logic [63:0] random_imm();
    int          nb;
    logic [63:0] v;
    nb = $urandom_range(0, 8);
    v = {$urandom, $urandom};
    if (nb < 8) v = v & ((64'd1 << (8 * nb)) - 64'd1);
    return v;
  endfunction

  function automatic logic [1:0] addr_size();
    if ($urandom_range(0, 4) == 0) return 2'($urandom_range(0, 3));
    return {1'b1, 1'($urandom_range(0, 1))};
  endfunction

  function automatic mov_req_t random_req();
    mov_req_t r;
    r.cnt = 2'd2;
    r.dk = mov_enc_pkg::KIND_REG;
    r.di = 1'b0;
    r.dc = 4'($urandom_range(0, 7));
    r.ds = 2'($urandom_range(0, 3));
    r.sk = mov_enc_pkg::KIND_REG;
    r.si = 1'b0;
    r.sc = 4'($urandom_range(0, 7));
    r.ss = 2'($urandom_range(0, 3));
    r.imm = {$urandom, $urandom};
    r.lbl = 12'($urandom_range(0, 4095));
    case ($urandom_range(0, 15))
      0, 1: r.ss = r.ds;
      2: ;
      3, 4: begin
        r.sk = mov_enc_pkg::KIND_IMM;
        r.si = 1'($urandom_range(0, 1));
        r.imm = random_imm();
      end
      5, 6: begin
        r.sk = mov_enc_pkg::KIND_IMM;
        r.di = 1'b1;
        r.si = 1'($urandom_range(0, 1));
        r.ds = addr_size();
        r.imm = random_imm();
      end
      7, 8: begin
        r.di = 1'b1;
        r.ds = addr_size();
      end
      9, 10: begin
        r.si = 1'b1;
        r.ss = addr_size();
      end
      11, 12: begin
        r.sk = mov_enc_pkg::KIND_LABEL;
        r.si = 1'($urandom_range(0, 1));
      end
      default: begin
        r.cnt = 2'($urandom_range(0, 3));
        r.dk = 2'($urandom_range(0, 3));
        r.di = 1'($urandom_range(0, 1));
        r.dc = 4'($urandom_range(0, 15));
        r.sk = 2'($urandom_range(0, 3));
        r.si = 1'($urandom_range(0, 1));
        r.sc = 4'($urandom_range(0, 15));
        r.imm = random_imm();
      end
    endcase
    return r;
  endfunction

  task automatic send_req(input mov_req_t r);
    operand_count  <= r.cnt;
    dest_kind      <= r.dk;
    dest_indirect  <= r.di;
    dest_code      <= r.dc;
    dest_size_log2 <= r.ds;
    src_kind       <= r.sk;
    src_indirect   <= r.si;
    src_code       <= r.sc;
    src_size_log2  <= r.ss;
    immediate      <= r.imm;
    label_id       <= r.lbl;
    start          <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic hold_off(input int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || valid) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int n;
    bit calm;
    calm = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_req(mk(2'd0, mov_enc_pkg::KIND_REG, 1'b0, 4'd0, mov_enc_pkg::SIZE_B,
                mov_enc_pkg::KIND_REG, 1'b0, 4'd0, mov_enc_pkg::SIZE_B, 64'd0, 12'd0));
    send_req(mk(2'd3, mov_enc_pkg::KIND_REG, 1'b0, 4'd1, mov_enc_pkg::SIZE_D,
                mov_enc_pkg::KIND_REG, 1'b0, 4'd2, mov_enc_pkg::SIZE_D, 64'd0, 12'd0));
    send_req(mk(2'd2, mov_enc_pkg::KIND_REG, 1'b0, 4'd7, mov_enc_pkg::SIZE_B,
                mov_enc_pkg::KIND_REG, 1'b0, 4'd7, mov_enc_pkg::SIZE_B, 64'd0, 12'd0));
    send_req(mk(2'd2, mov_enc_pkg::KIND_REG, 1'b0, 4'd0, mov_enc_pkg::SIZE_W,
                mov_enc_pkg::KIND_REG, 1'b0, 4'd5, mov_enc_pkg::SIZE_W, 64'd0, 12'd0));
    send_req(mk(2'd2, mov_enc_pkg::KIND_REG, 1'b0, 4'd3, mov_enc_pkg::SIZE_Q,
                mov_enc_pkg::KIND_REG, 1'b0, 4'd0, mov_enc_pkg::SIZE_Q, 64'd0, 12'd0));
    send_req(mk(2'd2, mov_enc_pkg::KIND_REG, 1'b0, 4'd3, mov_enc_pkg::SIZE_D,
                mov_enc_pkg::KIND_REG, 1'b0, 4'd0, mov_enc_pkg::SIZE_Q, 64'd0, 12'd0));
    send_req(mk(2'd2, mov_enc_pkg::KIND_REG, 1'b0, 4'd15, mov_enc_pkg::SIZE_D,
                mov_enc_pkg::KIND_REG, 1'b0, 4'd0, mov_enc_pkg::SIZE_D, 64'd0, 12'd0));
    send_req(mk(2'd2, mov_enc_pkg::KIND_REG, 1'b0, 4'd1, mov_enc_pkg::SIZE_Q,
                mov_enc_pkg::KIND_REG, 1'b1, 4'd8, mov_enc_pkg::SIZE_Q, 64'd0, 12'd0));
    send_req(mk(2'd2, mov_enc_pkg::KIND_IMM, 1'b0, 4'd15, mov_enc_pkg::SIZE_D,
                mov_enc_pkg::KIND_IMM, 1'b0, 4'd0, mov_enc_pkg::SIZE_D, 64'd5, 12'd0));
    send_req(mk(2'd2, 2'd3, 1'b1, 4'd15, mov_enc_pkg::SIZE_Q,
                2'd3, 1'b1, 4'd15, mov_enc_pkg::SIZE_Q, 64'd0, 12'd0));
    send_req(mk(2'd2, mov_enc_pkg::KIND_REG, 1'b0, 4'd7, mov_enc_pkg::SIZE_B,
                mov_enc_pkg::KIND_IMM, 1'b0, 4'd0, mov_enc_pkg::SIZE_B, 64'hFF, 12'd0));
    send_req(mk(2'd2, mov_enc_pkg::KIND_REG, 1'b0, 4'd2, mov_enc_pkg::SIZE_B,
                mov_enc_pkg::KIND_IMM, 1'b0, 4'd0, mov_enc_pkg::SIZE_B, 64'h100, 12'd0));
    send_req(mk(2'd2, mov_enc_pkg::KIND_REG, 1'b0, 4'd7, mov_enc_pkg::SIZE_W,
                mov_enc_pkg::KIND_IMM, 1'b0, 4'd0, mov_enc_pkg::SIZE_W, 64'hFFFF, 12'd0));
    send_req(mk(2'd2, mov_enc_pkg::KIND_REG, 1'b0, 4'd1, mov_enc_pkg::SIZE_W,
                mov_enc_pkg::KIND_IMM, 1'b0, 4'd0, mov_enc_pkg::SIZE_W, 64'h1_0000, 12'd0));
    send_req(mk(2'd2, mov_enc_pkg::KIND_REG, 1'b0, 4'd4, mov_enc_pkg::SIZE_D,
                mov_enc_pkg::KIND_IMM, 1'b1, 4'd0, mov_enc_pkg::SIZE_D, 64'hFFFF_FFFF,
                12'd0));
    send_req(mk(2'd2, mov_enc_pkg::KIND_REG, 1'b0, 4'd4, mov_enc_pkg::SIZE_D,
                mov_enc_pkg::KIND_IMM, 1'b0, 4'd0, mov_enc_pkg::SIZE_D, 64'h1_0000_0000,
                12'd0));
    send_req(mk(2'd2, mov_enc_pkg::KIND_REG, 1'b0, 4'd6, mov_enc_pkg::SIZE_Q,
                mov_enc_pkg::KIND_IMM, 1'b0, 4'd0, mov_enc_pkg::SIZE_Q, '1, 12'd0));
    send_req(mk(2'd2, mov_enc_pkg::KIND_REG, 1'b0, 4'd6, mov_enc_pkg::SIZE_Q,
                mov_enc_pkg::KIND_IMM, 1'b0, 4'd0, mov_enc_pkg::SIZE_Q, 64'd5, 12'd0));
    send_req(mk(2'd2, mov_enc_pkg::KIND_REG, 1'b1, 4'd0, mov_enc_pkg::SIZE_D,
                mov_enc_pkg::KIND_IMM, 1'b0, 4'd0, mov_enc_pkg::SIZE_B, 64'hFF, 12'd0));
    send_req(mk(2'd2, mov_enc_pkg::KIND_REG, 1'b1, 4'd7, mov_enc_pkg::SIZE_Q,
                mov_enc_pkg::KIND_IMM, 1'b1, 4'd0, mov_enc_pkg::SIZE_B, 64'h1234, 12'd0));
    send_req(mk(2'd2, mov_enc_pkg::KIND_REG, 1'b1, 4'd3, mov_enc_pkg::SIZE_D,
                mov_enc_pkg::KIND_IMM, 1'b0, 4'd0, mov_enc_pkg::SIZE_B, 64'h1234_5678,
                12'd0));
    send_req(mk(2'd2, mov_enc_pkg::KIND_REG, 1'b1, 4'd3, mov_enc_pkg::SIZE_B,
                mov_enc_pkg::KIND_IMM, 1'b0, 4'd0, mov_enc_pkg::SIZE_B, 64'h1_0000_0000,
                12'd0));
    send_req(mk(2'd2, mov_enc_pkg::KIND_REG, 1'b1, 4'd3, mov_enc_pkg::SIZE_W,
                mov_enc_pkg::KIND_IMM, 1'b0, 4'd0, mov_enc_pkg::SIZE_B, 64'd1, 12'd0));
    send_req(mk(2'd2, mov_enc_pkg::KIND_REG, 1'b1, 4'd5, mov_enc_pkg::SIZE_D,
                mov_enc_pkg::KIND_REG, 1'b0, 4'd6, mov_enc_pkg::SIZE_W, 64'd0, 12'd0));
    send_req(mk(2'd2, mov_enc_pkg::KIND_REG, 1'b0, 4'd2, mov_enc_pkg::SIZE_B,
                mov_enc_pkg::KIND_REG, 1'b1, 4'd7, mov_enc_pkg::SIZE_Q, 64'd0, 12'd0));
    send_req(mk(2'd2, mov_enc_pkg::KIND_REG, 1'b0, 4'd2, mov_enc_pkg::SIZE_Q,
                mov_enc_pkg::KIND_REG, 1'b1, 4'd7, mov_enc_pkg::SIZE_W, 64'd0, 12'd0));
    send_req(mk(2'd2, mov_enc_pkg::KIND_REG, 1'b0, 4'd7, mov_enc_pkg::SIZE_W,
                mov_enc_pkg::KIND_LABEL, 1'b1, 4'd0, mov_enc_pkg::SIZE_B, 64'd0, 12'hFFF));
    send_req(mk(2'd2, mov_enc_pkg::KIND_REG, 1'b1, 4'd1, mov_enc_pkg::SIZE_Q,
                mov_enc_pkg::KIND_REG, 1'b1, 4'd2, mov_enc_pkg::SIZE_Q, 64'd0, 12'd0));
    send_req(mk(2'd2, mov_enc_pkg::KIND_REG, 1'b1, 4'd1, mov_enc_pkg::SIZE_Q,
                mov_enc_pkg::KIND_LABEL, 1'b0, 4'd0, mov_enc_pkg::SIZE_Q, 64'd0, 12'd1));
    drain();

    for (n = 0; n < RANDOM_REQS; n++) begin
      if (n % 40 == 0) calm = ($urandom_range(0, 2) == 0);
      send_req(random_req());
      if (n == RANDOM_REQS / 2) drain();
      else if (n < RANDOM_REQS - CALM_TAIL && !calm && $urandom_range(0, 3) == 0)
        hold_off($urandom_range(1, 19));
    end

    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("run covered %0d requests giving %0d words,", requests, words);
    $display("%0d of them error words and %0d label markers", error_words, label_marks);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

>>> filelist.f
hdl/mov_enc_pkg.sv
hdl/mov_enc_front.sv
hdl/mov_enc_queue.sv
hdl/mov_enc_back.sv
hdl/x86_mov_instruction_encoder.sv
verif/mov_enc_checker.sv
verif/tb.sv
